[rtl/bctm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctm_pkg: shared types and constants for the block cache tag manager
// Request and result beat structs, operation codes, defaults.
// ----------------------------------------------------------------------------
package bctm_pkg;

    localparam int DEFAULT_ENTRIES = 32;
    localparam logic [31:0] DISK_COUNT_RESET = 32'd1024;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] block_number;
        logic [4:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [4:0]  granted_slot;
        logic        was_hit;
        logic        fetch_valid;
        logic [31:0] fetch_block;
        logic        write_valid;
        logic [31:0] write_block;
        logic        out_of_range;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] disk_read_total;
        logic [31:0] disk_write_total;
    } rsp_t;

    // cell status flowing down the chain: first hit and first free so far
    typedef struct packed {
        logic hit;
        logic free;
    } chain_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic        upd;      // apply update this cycle
        logic        acq_hit;  // increment refs at hit cell
        logic        install;  // retag victim
        logic        rel;      // decrement at slot
        logic        mark;     // set dirty at slot
        logic [31:0] tag;
    } cmd_t;

endpackage

[rtl/bctm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctm_cell: one cache entry of the search chain
// Holds valid, tag, refs and dirty; folds its match and free status into the chain status.
// ----------------------------------------------------------------------------
module bctm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     key,
    input  bctm_pkg::chain_t chain_in,
    output bctm_pkg::chain_t chain_out,
    output logic            hit_here,
    output logic            free_here,
    output logic [31:0]     tag,
    output logic            dirty,
    output logic            valid,
    input  bctm_pkg::cmd_t  cmd,
    input  logic            sel_hit,
    input  logic            sel_vic,
    input  logic            sel_slot
);
    import bctm_pkg::*;

    logic       valid_reg;
    logic [31:0] tag_reg;
    logic [7:0] refs_reg;
    logic       dirty_reg;
    logic       match;
    logic       is_free;

    assign match   = valid_reg && (tag_reg == key);
    assign is_free = !valid_reg || (refs_reg == 8'd0);

    // first-match priority along the chain
    assign hit_here  = match && !chain_in.hit;
    assign free_here = is_free && !chain_in.free;
    assign chain_out.hit  = chain_in.hit || match;
    assign chain_out.free = chain_in.free || is_free;

    assign tag   = tag_reg;
    assign dirty = dirty_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= '0;
            refs_reg  <= '0;
            dirty_reg <= 1'b0;
        end
        else if (cmd.upd)
        begin
            if (cmd.acq_hit && sel_hit)
            begin
                if (refs_reg != 8'hff)
                    refs_reg <= refs_reg + 8'd1;
            end
            else if (cmd.install && sel_vic)
            begin
                valid_reg <= 1'b1;
                tag_reg   <= cmd.tag;
                refs_reg  <= 8'd1;
                dirty_reg <= 1'b0;
            end
            else if (cmd.rel && sel_slot)
            begin
                if (refs_reg != 8'd0)
                    refs_reg <= refs_reg - 8'd1;
            end
            else if (cmd.mark && sel_slot)
            begin
                dirty_reg <= 1'b1;
            end
        end
    end

endmodule

[rtl/block_cache_tag_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_tag_manager: tag and reference-count manager for a block cache
// A request beat is registered; the cell chain search and the update then
// run in the update state, which also registers the result beat and waits
// while a result is unaccepted. Requests are taken only in the idle state,
// also with a result held. Reset: asynchronous, active low; all entries
// invalid, counters zero, disk_block_count 1024. No clearing pass.
// ----------------------------------------------------------------------------
module block_cache_tag_manager #(
    parameter int ENTRIES = bctm_pkg::DEFAULT_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bctm_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bctm_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);
    import bctm_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [31:0] disk_count_reg;
    logic [31:0] hits_reg, misses_reg, reads_reg, writes_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;

    chain_t      chain [ENTRIES+1];
    logic [ENTRIES-1:0] hit_v, free_v, dirty_v, valid_v, sel_vic, sel_slot;
    logic [31:0] tags [ENTRIES];
    cmd_t        cmd;

    logic [IW-1:0] hit_idx, free_idx, vic_idx;
    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    logic          is_hit;
    logic          wb_need, rd_need;
    logic [31:0]   wb_blk;
    logic          upd_go;
    rsp_t          rsp;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            bctm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .key      (req_reg.block_number),
                .chain_in (chain[g]),
                .chain_out(chain[g+1]),
                .hit_here (hit_v[g]),
                .free_here(free_v[g]),
                .tag      (tags[g]),
                .dirty    (dirty_v[g]),
                .valid    (valid_v[g]),
                .cmd      (cmd),
                .sel_hit  (hit_v[g]),
                .sel_vic  (sel_vic[g]),
                .sel_slot (sel_slot[g])
            );
            assign sel_vic[g]  = (vic_idx == IW'(g));
            assign sel_slot[g] = slot_ok && (slot_idx == IW'(g));
        end
    endgenerate

    // one-hot to index encoders
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_v[i])
                hit_idx = hit_idx | IW'(i);
            if (free_v[i])
                free_idx = free_idx | IW'(i);
        end
    end

    assign is_hit  = chain[ENTRIES].hit;
    assign vic_idx = chain[ENTRIES].free ? free_idx : '0;
    assign slot_ok = ({27'd0, req_reg.slot_index} < 32'(ENTRIES));
    assign slot_idx = IW'(req_reg.slot_index);

    // update and result land on the same edge; held off while a result waits
    assign upd_go = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd         = '0;
        cmd.upd     = upd_go;
        cmd.tag     = req_reg.block_number;
        wb_need     = 1'b0;
        wb_blk      = '0;
        rd_need     = 1'b0;
        case (op_t'(req_reg.operation))
            OP_ACQUIRE:
            begin
                cmd.acq_hit = is_hit;
                cmd.install = !is_hit;
                rd_need     = !is_hit;
                wb_need     = !is_hit && valid_v[vic_idx] && dirty_v[vic_idx];
                wb_blk      = tags[vic_idx];
            end
            OP_RELEASE: cmd.rel = 1'b1;
            OP_MARK:
            begin
                cmd.mark = 1'b1;
                wb_need  = slot_ok;
                wb_blk   = tags[slot_idx];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rsp = '0;
        rsp.granted_slot = req_reg.slot_index;
        if (op_t'(req_reg.operation) == OP_ACQUIRE)
            rsp.granted_slot = 5'(is_hit ? hit_idx : vic_idx);
        rsp.was_hit = (op_t'(req_reg.operation) == OP_ACQUIRE) && is_hit;
        if (rd_need)
        begin
            if (req_reg.block_number < disk_count_reg)
            begin
                rsp.fetch_valid = 1'b1;
                rsp.fetch_block = req_reg.block_number;
            end
            else
                rsp.out_of_range = 1'b1;
        end
        if (wb_need)
        begin
            if (wb_blk < disk_count_reg)
            begin
                rsp.write_valid = 1'b1;
                rsp.write_block = wb_blk;
            end
            else
                rsp.out_of_range = 1'b1;
        end
        rsp.hit_total  = hits_reg + {31'd0, rsp.was_hit};
        rsp.miss_total = misses_reg + {31'd0, rd_need};
        rsp.disk_read_total  = reads_reg + {31'd0, rsp.fetch_valid};
        rsp.disk_write_total = writes_reg + {31'd0, rsp.write_valid};
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            disk_count_reg <= DISK_COUNT_RESET;
            hits_reg       <= '0;
            misses_reg     <= '0;
            reads_reg      <= '0;
            writes_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                disk_count_reg <= cfg_data;
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (upd_go)
            begin
                hits_reg      <= rsp.hit_total;
                misses_reg    <= rsp.miss_total;
                reads_reg     <= rsp.disk_read_total;
                writes_reg    <= rsp.disk_write_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                req_reg <= in_data;
            if (upd_go)
                out_reg <= rsp;
        end
    end

`ifndef SYNTHESIS
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_v)) else $error("multiple first hits");
    a_no_fetch_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_hit |-> !out_data.fetch_valid)
        else $error("fetch on hit");
    a_update_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_UPDATE)
        else $error("update not entered");
`endif

endmodule
